// ===== rtl/core/pvs_pkg.sv =====
// Shared constants, register indexes and saturation helpers for the particle step.
`default_nettype none

package pvs_pkg;

   localparam int MAX_ATTRACTORS = 2;
   localparam int COORD_WIDTH    = 32;

   // Pipeline depths
   localparam int SQRT_STAGES = 32;
   localparam int DIV_STAGES  = 32;
   localparam int FORCE_PRE   = 5;
   localparam int FORCE_POST  = 3;
   localparam int FORCE_LAT   = FORCE_PRE + SQRT_STAGES + DIV_STAGES + FORCE_POST;
   localparam int COMBINE_LAT = 2;
   localparam int VERLET_LAT  = 3;
   localparam int TOTAL_LAT   = FORCE_LAT + COMBINE_LAT + VERLET_LAT;

   localparam int FORCE_W   = 41;
   localparam int FRAME_MAX = 4096;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] REG_VEL_DAMP   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ANG_DAMP   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FORCE_X    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_FORCE_Y    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SUBDIV     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTR_COUNT = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTR_ZERO  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_ATTR_ONE   = 3'd7;

   localparam logic signed [63:0] SAT32_HI = 64'sh0000_0000_7FFF_FFFF;
   localparam logic signed [63:0] SAT32_LO = 64'shFFFF_FFFF_8000_0000;
   localparam logic signed [63:0] COORD_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] COORD_LO = -COORD_HI - 64'sd1;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [63:0] c;
      if (v > SAT32_HI) begin
         c = SAT32_HI;
      end else if (v < SAT32_LO) begin
         c = SAT32_LO;
      end else begin
         c = v;
      end
      return c[31:0];
   endfunction

   function automatic logic signed [31:0] sat_coord(input logic signed [63:0] v);
      logic signed [63:0] c;
      if (v > COORD_HI) begin
         c = COORD_HI;
      end else if (v < COORD_LO) begin
         c = COORD_LO;
      end else begin
         c = v;
      end
      return c[31:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pvs_sqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module pvs_sqrt (
   input  logic        clock,
   input  logic        adv,
   input  logic [63:0] radicand,
   output logic [31:0] root
);
   import pvs_pkg::*;

   logic [33:0] rem_ff  [SQRT_STAGES];
   logic [31:0] root_ff [SQRT_STAGES];
   logic [63:0] rad_ff  [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      logic [33:0] rem_src;
      logic [31:0] root_src;
      logic [63:0] rad_src;
      logic [35:0] part;
      logic [35:0] trial;
      logic        fits;
      logic [33:0] rem_in;
      logic [31:0] root_in;
      logic [63:0] rad_in;

      if (k == 0) begin : g_first
         assign rem_src  = '0;
         assign root_src = '0;
         assign rad_src  = radicand;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
         assign rad_src  = rad_ff[k-1];
      end

      // bring down the next bit pair, try 4r+1
      assign part    = {rem_src, rad_src[63:62]};
      assign trial   = {2'b00, root_src, 2'b01};
      assign fits    = (part >= trial);
      assign rem_in  = fits ? 34'(part - trial) : part[33:0];
      assign root_in = {root_src[30:0], fits};
      assign rad_in  = {rad_src[61:0], 2'b00};

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_in;
         end
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/pvs_div.sv =====
// Pipelined restoring divider: 64-bit by 64-bit, 32 quotient bits plus overflow flag.
`default_nettype none

module pvs_div (
   input  logic        clock,
   input  logic        adv,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic [31:0] quotient,
   output logic        overflow
);
   import pvs_pkg::*;

   logic [63:0] rem_ff [DIV_STAGES];
   logic [31:0] quo_ff [DIV_STAGES];
   logic [31:0] low_ff [DIV_STAGES];
   logic [63:0] den_ff [DIV_STAGES];
   logic        ovf_ff [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [63:0] rem_src;
      logic [31:0] quo_src;
      logic [31:0] low_src;
      logic [63:0] den_src;
      logic        ovf_src;
      logic [64:0] part;
      logic        fits;
      logic [63:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_src = {32'd0, dividend[63:32]};
         assign quo_src = '0;
         assign low_src = dividend[31:0];
         assign den_src = divisor;
         // quotient needs more than 32 bits
         assign ovf_src = ({32'd0, dividend[63:32]} >= divisor);
      end else begin : g_next
         assign rem_src = rem_ff[k-1];
         assign quo_src = quo_ff[k-1];
         assign low_src = low_ff[k-1];
         assign den_src = den_ff[k-1];
         assign ovf_src = ovf_ff[k-1];
      end

      assign part   = {rem_src, low_src[31]};
      assign fits   = (part >= {1'b0, den_src});
      assign rem_in = fits ? 64'(part - {1'b0, den_src}) : part[63:0];

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= rem_in;
            quo_ff[k] <= {quo_src[30:0], fits};
            low_ff[k] <= {low_src[30:0], 1'b0};
            den_ff[k] <= den_src;
            ovf_ff[k] <= ovf_src;
         end
      end
   end

   assign quotient = quo_ff[DIV_STAGES-1];
   assign overflow = ovf_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/core/pvs_force.sv =====
// Attractor pull for one attractor: delta, lateral offset, linear or inverse-square force.
`default_nettype none

module pvs_force (
   input  logic                                 clock,
   input  logic                                 adv,
   input  logic [31:0]                          pos_x,
   input  logic [31:0]                          pos_y,
   input  logic [63:0]                          attractor,
   input  logic                                 enable,
   output logic signed [pvs_pkg::FORCE_W-1:0]   force_x,
   output logic signed [pvs_pkg::FORCE_W-1:0]   force_y
);
   import pvs_pkg::*;

   typedef struct packed {
      logic [15:0] pw;
      logic [14:0] lat;
      logic        inv;
      logic        en;
   } ctl_type;

   typedef struct packed {
      logic        sx;
      logic        sy;
      logic        sp;
      logic [31:0] adx;
      logic [31:0] ady;
      logic [15:0] apw;
      logic [63:0] s;
      logic        zero;
      logic        inv;
      logic        en;
      logic        big;
      logic [39:0] linx;
      logic [39:0] liny;
   } side_type;

   typedef struct packed {
      logic        zero;
      logic        inv;
      logic        en;
      logic [39:0] linx;
      logic [39:0] liny;
   } tail_type;

   // stage 1: raw delta
   logic [31:0]        loc_x;
   logic [31:0]        loc_y;
   logic signed [32:0] dxr_in;
   logic signed [32:0] dyr_in;
   logic signed [32:0] dxr_ff;
   logic signed [32:0] dyr_ff;
   ctl_type            ctl1_in;
   ctl_type            ctl1_ff;

   assign loc_x = {{8{attractor[15]}}, attractor[15:0], 8'h00};
   assign loc_y = {{8{attractor[31]}}, attractor[31:16], 8'h00};
   assign dxr_in = $signed({loc_x[31], loc_x}) - $signed({pos_x[31], pos_x});
   assign dyr_in = $signed({loc_y[31], loc_y}) - $signed({pos_y[31], pos_y});
   assign ctl1_in = '{pw: attractor[47:32], lat: attractor[62:48],
                      inv: attractor[63], en: enable};

   always_ff @(posedge clock) begin
      if (adv) begin
         dxr_ff  <= dxr_in;
         dyr_ff  <= dyr_in;
         ctl1_ff <= ctl1_in;
      end
   end

   // stage 2: lateral products
   logic signed [47:0] nx_ff;
   logic signed [47:0] ny_ff;
   logic signed [32:0] dxr2_ff;
   logic signed [32:0] dyr2_ff;
   ctl_type            ctl2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         nx_ff   <= dxr_ff * $signed(ctl1_ff.lat);
         ny_ff   <= dyr_ff * $signed(ctl1_ff.lat);
         dxr2_ff <= dxr_ff;
         dyr2_ff <= dyr_ff;
         ctl2_ff <= ctl1_ff;
      end
   end

   // stage 3: rotate the offset in and saturate the delta
   logic signed [48:0] dxs;
   logic signed [48:0] dys;
   logic signed [31:0] dx3_ff;
   logic signed [31:0] dy3_ff;
   ctl_type            ctl3_ff;

   assign dxs = 49'(dxr2_ff) - 49'(ny_ff >>> 8);
   assign dys = 49'(dyr2_ff) + 49'(nx_ff >>> 8);

   always_ff @(posedge clock) begin
      if (adv) begin
         dx3_ff  <= sat32(64'(dxs));
         dy3_ff  <= sat32(64'(dys));
         ctl3_ff <= ctl2_ff;
      end
   end

   // stage 4: squares and linear products
   logic signed [63:0] sqx_ff;
   logic signed [63:0] sqy_ff;
   logic signed [47:0] linx_ff;
   logic signed [47:0] liny_ff;
   logic [31:0]        adx4_ff;
   logic [31:0]        ady4_ff;
   logic               sx4_ff;
   logic               sy4_ff;
   logic               zero4_ff;
   ctl_type            ctl4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff   <= dx3_ff * dx3_ff;
         sqy_ff   <= dy3_ff * dy3_ff;
         linx_ff  <= dx3_ff * $signed(ctl3_ff.pw);
         liny_ff  <= dy3_ff * $signed(ctl3_ff.pw);
         adx4_ff  <= dx3_ff[31] ? 32'(-dx3_ff) : dx3_ff;
         ady4_ff  <= dy3_ff[31] ? 32'(-dy3_ff) : dy3_ff;
         sx4_ff   <= dx3_ff[31];
         sy4_ff   <= dy3_ff[31];
         zero4_ff <= (dx3_ff == 32'sd0) && (dy3_ff == 32'sd0);
         ctl4_ff  <= ctl3_ff;
      end
   end

   // stage 5: squared distance
   logic [63:0]        s5;
   logic signed [47:0] linx_sh;
   logic signed [47:0] liny_sh;
   side_type           side5_in;
   side_type           side5_ff;

   assign s5      = 64'(sqx_ff) + 64'(sqy_ff);
   assign linx_sh = linx_ff >>> 8;
   assign liny_sh = liny_ff >>> 8;

   always_comb begin
      side5_in.sx   = sx4_ff;
      side5_in.sy   = sy4_ff;
      side5_in.sp   = ctl4_ff.pw[15];
      side5_in.adx  = adx4_ff;
      side5_in.ady  = ady4_ff;
      side5_in.apw  = ctl4_ff.pw[15] ? 16'(-ctl4_ff.pw) : ctl4_ff.pw;
      side5_in.s    = s5;
      side5_in.zero = zero4_ff;
      side5_in.inv  = ctl4_ff.inv;
      side5_in.en   = ctl4_ff.en;
      side5_in.big  = s5[63] | s5[62];
      side5_in.linx = linx_sh[39:0];
      side5_in.liny = liny_sh[39:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side5_ff <= side5_in;
      end
   end

   // distance root, side data held alongside
   logic [31:0] dist_root;
   side_type    sqside_ff [SQRT_STAGES];

   pvs_sqrt u_sqrt (
      .clock    (clock),
      .adv      (adv),
      .radicand (side5_ff.s),
      .root     (dist_root)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         sqside_ff[0] <= side5_ff;
         for (int k = 1; k < SQRT_STAGES; k++) begin
            sqside_ff[k] <= sqside_ff[k-1];
         end
      end
   end

   // unit vector and magnitude divisions
   side_type    sq_out;
   logic [31:0] qx;
   logic [31:0] qy;
   logic [31:0] qm;
   logic        ovf_x;
   logic        ovf_y;
   logic        ovf_m;
   side_type    dvside_ff [DIV_STAGES];

   assign sq_out = sqside_ff[SQRT_STAGES-1];

   pvs_div u_div_x (
      .clock    (clock),
      .adv      (adv),
      .dividend ({2'b00, sq_out.adx, 30'd0}),
      .divisor  ({32'd0, dist_root}),
      .quotient (qx),
      .overflow (ovf_x)
   );

   pvs_div u_div_y (
      .clock    (clock),
      .adv      (adv),
      .dividend ({2'b00, sq_out.ady, 30'd0}),
      .divisor  ({32'd0, dist_root}),
      .quotient (qy),
      .overflow (ovf_y)
   );

   pvs_div u_div_m (
      .clock    (clock),
      .adv      (adv),
      .dividend ({8'd0, sq_out.apw, 40'd0}),
      .divisor  (sq_out.s),
      .quotient (qm),
      .overflow (ovf_m)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         dvside_ff[0] <= sq_out;
         for (int k = 1; k < DIV_STAGES; k++) begin
            dvside_ff[k] <= dvside_ff[k-1];
         end
      end
   end

   // stage 6: signs back on, saturate magnitude
   side_type           dv_out;
   logic signed [31:0] ux_in;
   logic signed [31:0] uy_in;
   logic signed [31:0] m_in;
   logic signed [31:0] ux6_ff;
   logic signed [31:0] uy6_ff;
   logic signed [31:0] m6_ff;
   tail_type           tail6_ff;
   tail_type           tail7_ff;

   assign dv_out = dvside_ff[DIV_STAGES-1];

   // unit-vector quotients never exceed 2^30; overflow rises only for a zero delta
   assign ux_in = (dv_out.sx && !ovf_x) ? 32'(-qx) : qx;
   assign uy_in = (dv_out.sy && !ovf_y) ? 32'(-qy) : qy;

   always_comb begin
      priority if (dv_out.big) begin
         m_in = '0;
      end else if (!dv_out.sp) begin
         m_in = (ovf_m || qm[31]) ? 32'h7FFF_FFFF : qm;
      end else begin
         m_in = (ovf_m || (qm > 32'h8000_0000)) ? 32'h8000_0000 : 32'(-qm);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ux6_ff   <= ux_in;
         uy6_ff   <= uy_in;
         m6_ff    <= m_in;
         tail6_ff <= '{zero: dv_out.zero, inv: dv_out.inv, en: dv_out.en,
                       linx: dv_out.linx, liny: dv_out.liny};
      end
   end

   // stage 7: scale unit vector by magnitude
   logic signed [63:0] px7_ff;
   logic signed [63:0] py7_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         px7_ff   <= ux6_ff * m6_ff;
         py7_ff   <= uy6_ff * m6_ff;
         tail7_ff <= tail6_ff;
      end
   end

   // stage 8: pick the law, drop disabled or zero-delta pulls
   logic signed [63:0]        px_sh;
   logic signed [63:0]        py_sh;
   logic signed [FORCE_W-1:0] fx_in;
   logic signed [FORCE_W-1:0] fy_in;
   logic signed [FORCE_W-1:0] fx_ff;
   logic signed [FORCE_W-1:0] fy_ff;

   assign px_sh = px7_ff >>> 30;
   assign py_sh = py7_ff >>> 30;

   always_comb begin
      priority if (!tail7_ff.en || tail7_ff.zero) begin
         fx_in = '0;
         fy_in = '0;
      end else if (tail7_ff.inv) begin
         fx_in = FORCE_W'(px_sh);
         fy_in = FORCE_W'(py_sh);
      end else begin
         fx_in = FORCE_W'($signed(tail7_ff.linx));
         fy_in = FORCE_W'($signed(tail7_ff.liny));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fx_ff <= fx_in;
         fy_ff <= fy_in;
      end
   end

   assign force_x = fx_ff;
   assign force_y = fy_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pvs_verlet.sv =====
// Damped Verlet step for one coordinate: products, combine, add force and saturate.
`default_nettype none

module pvs_verlet (
   input  logic        clock,
   input  logic        adv,
   input  logic [31:0] cur,
   input  logic [31:0] prev,
   input  logic [15:0] damp,
   input  logic [31:0] force_add,
   output logic [31:0] result
);
   import pvs_pkg::*;

   logic signed [17:0] kc;
   logic signed [17:0] kp;
   logic signed [49:0] pc_ff;
   logic signed [49:0] pp_ff;
   logic signed [50:0] acc;
   logic signed [35:0] sh_ff;
   logic signed [36:0] sum;
   logic signed [31:0] result_ff;

   // (2-d) and (1-d) in Q1.15 units
   assign kc = 18'sd65536 - $signed({2'b00, damp});
   assign kp = 18'sd32768 - $signed({2'b00, damp});

   assign acc = 51'(pc_ff) - 51'(pp_ff);
   assign sum = 37'(sh_ff) + 37'($signed(force_add));

   always_ff @(posedge clock) begin
      if (adv) begin
         pc_ff     <= $signed(cur) * kc;
         pp_ff     <= $signed(prev) * kp;
         sh_ff     <= 36'(acc >>> 15);
         result_ff <= sat_coord(64'(sum));
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

// ===== rtl/core/particle_verlet_step_top.sv =====
// Top level of the particle Verlet step: registers, attractor units, combine and integrate.
`default_nettype none

// Channel    Direction  Handshake           Payload
// request    in         req_valid/req_stall pos, prev, angles, frame_in, step_frame
// response   out        rsp_valid/rsp_stall new pos, new prev, angles, frame_out
// csr        in         csr_valid/csr_ready csr_index (3 bits), csr_wdata (64 bits)
//
// One request enters every cycle unless a held response freezes the pipe; each gives
// one response. Latency is set by the attractor path: a 32-stage square root followed by
// 32-stage dividers, plus pre/post stages, the attractor combine and the Verlet stage.
// Reset is synchronous and active high; it clears valid bits and config registers, but
// sets the subdivision count to 1. A response held by rsp_stall freezes the whole pipe:
// req_stall rises in the same cycle and nothing in flight is lost or repeated.

module particle_verlet_step_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_prev_x,
   input  logic [31:0] req_prev_y,
   input  logic [31:0] req_angle_now,
   input  logic [31:0] req_angle_prev,
   input  logic [11:0] req_frame_in,
   input  logic        req_step_frame,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_new_pos_x,
   output logic [31:0] rsp_new_pos_y,
   output logic [31:0] rsp_new_prev_x,
   output logic [31:0] rsp_new_prev_y,
   output logic [31:0] rsp_new_angle,
   output logic [31:0] rsp_new_angle_prev,
   output logic [11:0] rsp_frame_out,

   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pvs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [63:0]                        csr_wdata
);
   import pvs_pkg::*;

   typedef struct packed {
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] qx;
      logic [31:0] qy;
      logic [31:0] an;
      logic [31:0] ap;
      logic [11:0] frame;
   } item_type;

   typedef struct packed {
      logic [31:0] px;
      logic [31:0] py;
      logic [31:0] an;
      logic [11:0] frame;
   } tail_type;

   // ---------------------------------------------------------------
   // Configuration registers; writes always accepted
   // ---------------------------------------------------------------
   logic [15:0] velocity_damping_ff;
   logic [15:0] angular_damping_ff;
   logic [31:0] force_step_x_ff;
   logic [31:0] force_step_y_ff;
   logic [12:0] subdivision_count_ff;
   logic [1:0]  attractor_count_ff;
   logic [63:0] attractor_zero_ff;
   logic [63:0] attractor_one_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         velocity_damping_ff  <= '0;
         angular_damping_ff   <= '0;
         force_step_x_ff      <= '0;
         force_step_y_ff      <= '0;
         subdivision_count_ff <= 13'd1;
         attractor_count_ff   <= '0;
         attractor_zero_ff    <= '0;
         attractor_one_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_VEL_DAMP:   velocity_damping_ff  <= csr_wdata[15:0];
            REG_ANG_DAMP:   angular_damping_ff   <= csr_wdata[15:0];
            REG_FORCE_X:    force_step_x_ff      <= csr_wdata[31:0];
            REG_FORCE_Y:    force_step_y_ff      <= csr_wdata[31:0];
            REG_SUBDIV:     subdivision_count_ff <= csr_wdata[12:0];
            REG_ATTR_COUNT: attractor_count_ff   <= csr_wdata[1:0];
            REG_ATTR_ZERO:  attractor_zero_ff    <= csr_wdata;
            REG_ATTR_ONE:   attractor_one_ff     <= csr_wdata;
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Global advance: hold everything while the response is stalled
   // ---------------------------------------------------------------
   logic adv;
   logic valid_ff [TOTAL_LAT];

   assign adv       = !(valid_ff[TOTAL_LAT-1] && rsp_stall);
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TOTAL_LAT; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         valid_ff[0] <= req_valid;
         for (int k = 1; k < TOTAL_LAT; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Frame advance, done at entry
   // ---------------------------------------------------------------
   logic [12:0] cnt_eff;
   logic [12:0] frame_base;
   logic [12:0] frame_inc;
   logic [11:0] frame_next;

   always_comb begin
      priority if (subdivision_count_ff == 13'd0) begin
         cnt_eff = 13'd1;
      end else if (subdivision_count_ff > 13'(FRAME_MAX)) begin
         cnt_eff = 13'(FRAME_MAX);
      end else begin
         cnt_eff = subdivision_count_ff;
      end
   end

   assign frame_base = ({1'b0, req_frame_in} >= cnt_eff) ? 13'd0 : {1'b0, req_frame_in};
   assign frame_inc  = frame_base + 13'd1;

   always_comb begin
      if (req_step_frame) begin
         frame_next = (frame_inc >= cnt_eff) ? 12'd0 : frame_inc[11:0];
      end else begin
         frame_next = frame_base[11:0];
      end
   end

   // ---------------------------------------------------------------
   // Attractor units run side by side; pulls are applied in order later
   // ---------------------------------------------------------------
   logic                      en_zero;
   logic                      en_one;
   logic signed [FORCE_W-1:0] f0x;
   logic signed [FORCE_W-1:0] f0y;
   logic signed [FORCE_W-1:0] f1x;
   logic signed [FORCE_W-1:0] f1y;

   assign en_zero = (attractor_count_ff != 2'd0) && (MAX_ATTRACTORS > 0);
   assign en_one  = attractor_count_ff[1] && (MAX_ATTRACTORS > 1);

   pvs_force u_force_zero (
      .clock     (clock),
      .adv       (adv),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .attractor (attractor_zero_ff),
      .enable    (en_zero),
      .force_x   (f0x),
      .force_y   (f0y)
   );

   pvs_force u_force_one (
      .clock     (clock),
      .adv       (adv),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .attractor (attractor_one_ff),
      .enable    (en_one),
      .force_x   (f1x),
      .force_y   (f1y)
   );

   // hold the particle alongside the attractor pipe
   item_type item_in;
   item_type item_ff [FORCE_LAT];

   assign item_in = '{px: req_pos_x, py: req_pos_y, qx: req_prev_x, qy: req_prev_y,
                      an: req_angle_now, ap: req_angle_prev, frame: frame_next};

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff[0] <= item_in;
         for (int k = 1; k < FORCE_LAT; k++) begin
            item_ff[k] <= item_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------
   // Combine: subtract attractor zero, then attractor one, saturating each
   // ---------------------------------------------------------------
   item_type                  c0;
   logic signed [41:0]        c1x;
   logic signed [41:0]        c1y;
   item_type                  c1_in;
   item_type                  c1_ff;
   logic signed [FORCE_W-1:0] f1x_ff;
   logic signed [FORCE_W-1:0] f1y_ff;
   logic signed [41:0]        c2x;
   logic signed [41:0]        c2y;
   item_type                  c2_in;
   item_type                  c2_ff;

   assign c0  = item_ff[FORCE_LAT-1];
   assign c1x = 42'($signed(c0.qx)) - 42'(f0x);
   assign c1y = 42'($signed(c0.qy)) - 42'(f0y);
   assign c2x = 42'($signed(c1_ff.qx)) - 42'(f1x_ff);
   assign c2y = 42'($signed(c1_ff.qy)) - 42'(f1y_ff);

   always_comb begin
      c1_in    = c0;
      c1_in.qx = sat32(64'(c1x));
      c1_in.qy = sat32(64'(c1y));
      c2_in    = c1_ff;
      c2_in.qx = sat32(64'(c2x));
      c2_in.qy = sat32(64'(c2y));
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c1_ff  <= c1_in;
         f1x_ff <= f1x;
         f1y_ff <= f1y;
         c2_ff  <= c2_in;
      end
   end

   // ---------------------------------------------------------------
   // Verlet integration: x, y and rotation
   // ---------------------------------------------------------------
   logic [31:0] vx;
   logic [31:0] vy;
   logic [31:0] va;

   pvs_verlet u_verlet_x (
      .clock     (clock),
      .adv       (adv),
      .cur       (c2_ff.px),
      .prev      (c2_ff.qx),
      .damp      (velocity_damping_ff),
      .force_add (force_step_x_ff),
      .result    (vx)
   );

   pvs_verlet u_verlet_y (
      .clock     (clock),
      .adv       (adv),
      .cur       (c2_ff.py),
      .prev      (c2_ff.qy),
      .damp      (velocity_damping_ff),
      .force_add (force_step_y_ff),
      .result    (vy)
   );

   pvs_verlet u_verlet_a (
      .clock     (clock),
      .adv       (adv),
      .cur       (c2_ff.an),
      .prev      (c2_ff.ap),
      .damp      (angular_damping_ff),
      .force_add (32'd0),
      .result    (va)
   );

   tail_type tail_ff [VERLET_LAT];

   always_ff @(posedge clock) begin
      if (adv) begin
         tail_ff[0] <= '{px: c2_ff.px, py: c2_ff.py, an: c2_ff.an, frame: c2_ff.frame};
         for (int k = 1; k < VERLET_LAT; k++) begin
            tail_ff[k] <= tail_ff[k-1];
         end
      end
   end

   assign rsp_valid          = valid_ff[TOTAL_LAT-1];
   assign rsp_new_pos_x      = vx;
   assign rsp_new_pos_y      = vy;
   assign rsp_new_prev_x     = tail_ff[VERLET_LAT-1].px;
   assign rsp_new_prev_y     = tail_ff[VERLET_LAT-1].py;
   assign rsp_new_angle      = va;
   assign rsp_new_angle_prev = tail_ff[VERLET_LAT-1].an;
   assign rsp_frame_out      = tail_ff[VERLET_LAT-1].frame;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("held response does not stop the request side");

   a_freeze_keeps_response: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> rsp_valid)
      else $error("response lost while pipe was frozen");

   a_empty_output_flows: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with no response pending");

endmodule

`default_nettype wire
